// ===== rtl/clsd_pkg.sv =====
// Shared types and constants for the circular list search/delete block.
// Used by the item interfaces, the storage cell and the top level.
package clsd_pkg;

	localparam int CAPACITY     = 16;
	localparam int RESULT_LIMIT = 16;
	localparam int DATAW        = 32;
	localparam int IDXW         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNTW         = $clog2(CAPACITY + 1);
	localparam int HITW         = $clog2(RESULT_LIMIT + 1);

	typedef enum logic [1:0] {
		REQ_INS_FRONT = 2'd0,
		REQ_INS_BACK  = 2'd1,
		REQ_SEARCH    = 2'd2,
		REQ_DELETE    = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_FULL      = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_FOUND     = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_REMOVED   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_INS_FRONT,
		CELL_INS_BACK,
		CELL_ROT_KEEP,
		CELL_ROT_DROP
	} cell_op_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_FLUSH
	} fsm_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		cell_op_t          op;
		logic [DATAW-1:0]  value;
		logic [CNTW-1:0]   len;
		logic [CNTW-1:0]   len_m1;
	} cell_cmd_t;

endpackage

// ===== rtl/clsd_if.sv =====
// Request and response item channels of the circular list block.
// Depends on clsd_pkg for the payload widths.
interface clsd_req_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  req_type;
	logic signed [clsd_pkg::DATAW-1:0] item_value;

	modport source(output valid, output req_type, output item_value, input ready);
	modport sink(input valid, input req_type, input item_value, output ready);
endinterface

interface clsd_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [3:0] position;
	logic [4:0] removed_count;
	logic       last;

	modport source(output valid, output status, output position, output removed_count,
		output last, input ready);
	modport sink(input valid, input status, input position, input removed_count,
		input last, output ready);
endinterface

// ===== rtl/clsd_cell.sv =====
// One storage cell of the list chain: holds a single entry and takes its
// next value from itself, a neighbor, the head or the inserted item. Uses clsd_pkg.
module clsd_cell (
	input  logic                          clk,
	input  clsd_pkg::cell_cmd_t           cmd,
	input  logic [clsd_pkg::IDXW-1:0]     idx,
	input  logic [clsd_pkg::DATAW-1:0]    left,
	input  logic [clsd_pkg::DATAW-1:0]    right,
	input  logic [clsd_pkg::DATAW-1:0]    head,
	output logic [clsd_pkg::DATAW-1:0]    entry
);

	logic [clsd_pkg::DATAW-1:0] entry_q;
	logic [clsd_pkg::DATAW-1:0] entry_d;
	logic [clsd_pkg::CNTW-1:0]  idx_w;

	assign idx_w = clsd_pkg::CNTW'(idx);

	always_comb begin
		entry_d = entry_q;
		case (cmd.op)
			clsd_pkg::CELL_INS_FRONT: begin
				entry_d = (idx_w == '0) ? cmd.value : left;
			end
			clsd_pkg::CELL_INS_BACK: begin
				if (idx_w == cmd.len) begin
					entry_d = cmd.value;
				end
			end
			// The head re-enters at the tail of the occupied part of the chain.
			clsd_pkg::CELL_ROT_KEEP: begin
				entry_d = (idx_w == cmd.len_m1) ? head : right;
			end
			clsd_pkg::CELL_ROT_DROP: begin
				entry_d = right;
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry = entry_q;

endmodule

// ===== rtl/circular_list_search_delete_core.sv =====
// Top level of the circular list search/delete block: a chain of storage
// cells and the sequencer that walks it. Uses clsd_pkg, clsd_if and clsd_cell.

// The list lives in a chain of CAPACITY cells, front at cell 0. A search
// or delete rotates the occupied part of the chain one entry per cycle past
// cell 0, a search stalling while a held match waits for the response slot.
// At the end the chain is in its original order (compacted after a delete).
// A search holds back each match until the next one or the end of the walk,
// so the final result can be marked last. One request is handled at a time.
module circular_list_search_delete_core (
	input  logic   clk,
	input  logic   arst_n,
	clsd_req_if.sink   req,
	clsd_rsp_if.source rsp
);

	localparam int CAP = clsd_pkg::CAPACITY;

	clsd_pkg::fsm_t    state_q, state_d;
	clsd_pkg::cell_cmd_t cmd;

	logic [clsd_pkg::CNTW-1:0]  count_q, count_d;
	logic [clsd_pkg::CNTW-1:0]  n_q, n_d;
	logic [clsd_pkg::IDXW-1:0]  step_q, step_d;
	logic [1:0]                 kind_q, kind_d;
	logic [clsd_pkg::DATAW-1:0] value_q, value_d;
	logic                       found_q, found_d;
	logic [3:0]                 held_q, held_d;
	logic [clsd_pkg::HITW-1:0]  hits_q, hits_d;
	logic [clsd_pkg::CNTW-1:0]  removed_q, removed_d;

	logic       rsp_valid_q;
	logic [2:0] rsp_status_q;
	logic [3:0] rsp_pos_q;
	logic [4:0] rsp_removed_q;
	logic       rsp_last_q;

	logic       slot_free;
	logic       emit;
	logic [2:0] emit_status;
	logic [3:0] emit_pos;
	logic [4:0] emit_removed;
	logic       emit_last;
	logic       req_ready;
	logic       match;
	logic       last_step;
	logic       take;

	logic [clsd_pkg::DATAW-1:0] cell_val [CAP];

	genvar j;
	generate
		for (j = 0; j < CAP; j++) begin : g_cell
			logic [clsd_pkg::DATAW-1:0] left_v;
			logic [clsd_pkg::DATAW-1:0] right_v;
			if (j == 0) begin : g_first
				assign left_v = cmd.value;
			end else begin : g_mid
				assign left_v = cell_val[j-1];
			end
			if (j == CAP - 1) begin : g_last
				assign right_v = cell_val[0];
			end else begin : g_inner
				assign right_v = cell_val[j+1];
			end
			clsd_cell u_cell (
				.clk   (clk),
				.cmd   (cmd),
				.idx   (clsd_pkg::IDXW'(j)),
				.left  (left_v),
				.right (right_v),
				.head  (cell_val[0]),
				.entry (cell_val[j])
			);
		end
	endgenerate

	assign slot_free = !rsp_valid_q || rsp.ready;
	assign match     = (cell_val[0] == value_q);
	assign last_step = (clsd_pkg::CNTW'(step_q) == n_q - clsd_pkg::CNTW'(1));
	assign take      = match && (hits_q < clsd_pkg::HITW'(clsd_pkg::RESULT_LIMIT));

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		n_d       = n_q;
		step_d    = step_q;
		kind_d    = kind_q;
		value_d   = value_q;
		found_d   = found_q;
		held_d    = held_q;
		hits_d    = hits_q;
		removed_d = removed_q;

		cmd.op     = clsd_pkg::CELL_HOLD;
		cmd.value  = req.item_value;
		cmd.len    = count_q;
		cmd.len_m1 = count_q - clsd_pkg::CNTW'(1);

		req_ready    = 1'b0;
		emit         = 1'b0;
		emit_status  = clsd_pkg::ST_INSERTED;
		emit_pos     = '0;
		emit_removed = '0;
		emit_last    = 1'b1;

		case (state_q)
			clsd_pkg::FSM_IDLE: begin
				req_ready = slot_free;
				if (req.valid && slot_free) begin
					case (clsd_pkg::req_t'(req.req_type))
						clsd_pkg::REQ_INS_FRONT, clsd_pkg::REQ_INS_BACK: begin
							emit = 1'b1;
							if (count_q >= clsd_pkg::CNTW'(CAP)) begin
								emit_status = clsd_pkg::ST_FULL;
							end else begin
								cmd.op = (clsd_pkg::req_t'(req.req_type) ==
									clsd_pkg::REQ_INS_FRONT) ?
									clsd_pkg::CELL_INS_FRONT : clsd_pkg::CELL_INS_BACK;
								count_d     = count_q + clsd_pkg::CNTW'(1);
								emit_status = clsd_pkg::ST_INSERTED;
							end
						end
						default: begin
							if (count_q == '0) begin
								emit        = 1'b1;
								emit_status = clsd_pkg::ST_EMPTY;
							end else begin
								kind_d    = req.req_type;
								value_d   = req.item_value;
								n_d       = count_q;
								step_d    = '0;
								found_d   = 1'b0;
								hits_d    = '0;
								removed_d = '0;
								state_d   = clsd_pkg::FSM_SCAN;
							end
						end
					endcase
				end
			end
			clsd_pkg::FSM_SCAN: begin
				if (kind_q == clsd_pkg::REQ_DELETE) begin
					// A dropped head shrinks the ring, so the survivors stay in order.
					if (match) begin
						cmd.op    = clsd_pkg::CELL_ROT_DROP;
						count_d   = count_q - clsd_pkg::CNTW'(1);
						removed_d = removed_q + clsd_pkg::CNTW'(1);
					end else begin
						cmd.op = clsd_pkg::CELL_ROT_KEEP;
					end
					step_d = clsd_pkg::IDXW'(step_q + 1'b1);
					if (last_step) begin
						state_d = clsd_pkg::FSM_FLUSH;
					end
				end else if (!(take && found_q && !slot_free)) begin
					cmd.op = clsd_pkg::CELL_ROT_KEEP;
					if (take) begin
						if (found_q) begin
							emit        = 1'b1;
							emit_status = clsd_pkg::ST_FOUND;
							emit_pos    = held_q;
							emit_last   = 1'b0;
						end
						held_d  = 4'(step_q);
						found_d = 1'b1;
						hits_d  = hits_q + clsd_pkg::HITW'(1);
					end
					step_d = clsd_pkg::IDXW'(step_q + 1'b1);
					if (last_step) begin
						state_d = clsd_pkg::FSM_FLUSH;
					end
				end
			end
			clsd_pkg::FSM_FLUSH: begin
				if (slot_free) begin
					emit    = 1'b1;
					state_d = clsd_pkg::FSM_IDLE;
					if (kind_q == clsd_pkg::REQ_DELETE) begin
						if (removed_q != '0) begin
							emit_status  = clsd_pkg::ST_REMOVED;
							emit_removed = 5'(removed_q);
						end else begin
							emit_status = clsd_pkg::ST_NOT_FOUND;
						end
					end else if (found_q) begin
						emit_status = clsd_pkg::ST_FOUND;
						emit_pos    = held_q;
					end else begin
						emit_status = clsd_pkg::ST_NOT_FOUND;
					end
				end
			end
			default: begin
				state_d = clsd_pkg::FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= clsd_pkg::FSM_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		n_q       <= n_d;
		step_q    <= step_d;
		kind_q    <= kind_d;
		value_q   <= value_d;
		found_q   <= found_d;
		held_q    <= held_d;
		hits_q    <= hits_d;
		removed_q <= removed_d;
		if (emit) begin
			rsp_status_q  <= emit_status;
			rsp_pos_q     <= emit_pos;
			rsp_removed_q <= emit_removed;
			rsp_last_q    <= emit_last;
		end
	end

	assign req.ready         = req_ready;
	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.position      = rsp_pos_q;
	assign rsp.removed_count = rsp_removed_q;
	assign rsp.last          = rsp_last_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= clsd_pkg::CNTW'(CAP))
		else $error("entry count above capacity");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> (state_q == clsd_pkg::FSM_IDLE))
		else $error("request accepted while a walk is in progress");

	a_delete_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == clsd_pkg::FSM_SCAN && kind_q == clsd_pkg::REQ_DELETE)
		|=> count_q <= $past(count_q))
		else $error("delete walk grew the list");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == clsd_pkg::FSM_SCAN) |-> (clsd_pkg::CNTW'(step_q) < n_q))
		else $error("walk ran past the stored entries");
`endif

endmodule

// ===== tb/clsd_list_checker.sv =====
// Checker for the circular list block: watches both item channels, keeps its own
// copy of the list and compares every response item with the predicted one.
// Depends on clsd_pkg and the item interfaces in clsd_if.
module clsd_list_checker (
	input  logic       clk,
	input  logic       arst_n,
	clsd_req_if        req,
	clsd_rsp_if        rsp,
	output int         mismatches,
	output int         outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		clsd_pkg::status_t status;
		logic [3:0]        position;
		logic [4:0]        removed_count;
		logic              last;
	} rsp_item_t;

	logic signed [clsd_pkg::DATAW-1:0] stored[$];
	rsp_item_t                         awaited_rsp[$];

	function automatic rsp_item_t make_rsp(clsd_pkg::status_t status, int position,
		int removed, logic last);
		rsp_item_t r;
		r.status        = status;
		r.position      = position[3:0];
		r.removed_count = removed[4:0];
		r.last          = last;
		return r;
	endfunction

	// Applies one request to the list copy and queues the response items it causes.
	task automatic apply_list_request(clsd_pkg::req_t kind,
		logic signed [clsd_pkg::DATAW-1:0] value);
		rsp_item_t                         hits[$];
		logic signed [clsd_pkg::DATAW-1:0] kept[$];
		int                                removed;
		case (kind)
			clsd_pkg::REQ_INS_FRONT, clsd_pkg::REQ_INS_BACK: begin
				if (stored.size() >= clsd_pkg::CAPACITY) begin
					awaited_rsp.push_back(make_rsp(clsd_pkg::ST_FULL, 0, 0, 1'b1));
				end else begin
					if (kind == clsd_pkg::REQ_INS_FRONT)
						stored.push_front(value);
					else
						stored.push_back(value);
					awaited_rsp.push_back(make_rsp(clsd_pkg::ST_INSERTED, 0, 0, 1'b1));
				end
			end
			default: begin
				if (stored.size() == 0) begin
					awaited_rsp.push_back(make_rsp(clsd_pkg::ST_EMPTY, 0, 0, 1'b1));
				end else if (kind == clsd_pkg::REQ_SEARCH) begin
					foreach (stored[i])
						if (stored[i] == value && hits.size() < clsd_pkg::RESULT_LIMIT)
							hits.push_back(make_rsp(clsd_pkg::ST_FOUND, i, 0, 1'b0));
					if (hits.size() == 0) begin
						awaited_rsp.push_back(make_rsp(clsd_pkg::ST_NOT_FOUND, 0, 0, 1'b1));
					end else begin
						hits[hits.size() - 1].last = 1'b1;
						foreach (hits[i])
							awaited_rsp.push_back(hits[i]);
					end
				end else begin
					foreach (stored[i])
						if (stored[i] != value)
							kept.push_back(stored[i]);
					removed = stored.size() - kept.size();
					stored = kept;
					if (removed == 0)
						awaited_rsp.push_back(make_rsp(clsd_pkg::ST_NOT_FOUND, 0, 0, 1'b1));
					else
						awaited_rsp.push_back(make_rsp(clsd_pkg::ST_REMOVED, 0, removed,
							1'b1));
				end
			end
		endcase
	endtask

	task automatic compare_field(string field, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n) begin
			// A response taken at the same edge as a request belongs to an earlier one.
			if (rsp.valid && rsp.ready) begin
				if (awaited_rsp.size() == 0) begin
					$display("%0t: unexpected response, expected none, actual status %0d pos %0d",
						$time, rsp.status, rsp.position);
					mismatches++;
				end else begin
					want = awaited_rsp.pop_front();
					compare_field("status", want.status, rsp.status);
					compare_field("position", want.position, rsp.position);
					compare_field("removed_count", want.removed_count, rsp.removed_count);
					compare_field("last", want.last, rsp.last);
				end
			end
			if (req.valid && req.ready)
				apply_list_request(clsd_pkg::req_t'(req.req_type), req.item_value);
		end
		outstanding <= awaited_rsp.size();
	end

endmodule

// ===== tb/tb.sv =====
// Top of the circular list testbench: clock, reset, request and response traffic.
// Depends on clsd_pkg, clsd_if, the core and clsd_list_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_ITEMS = 360;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   mismatches;
	int   outstanding;
	int   cycles = 0;
	bit   idle_on = 1'b1;
	bit   hold_pending = 1'b0;

	clsd_req_if req_ch();
	clsd_rsp_if rsp_ch();

	circular_list_search_delete_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	clsd_list_checker list_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	function automatic int draw_wait();
		if (!idle_on)
			return 0;
		return $urandom_range(0, 12);
	endfunction

	function automatic logic signed [clsd_pkg::DATAW-1:0] corner_value();
		case ($urandom_range(0, 3))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	task automatic send_item(clsd_pkg::req_t kind, logic signed [clsd_pkg::DATAW-1:0] value);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= kind;
		req_ch.item_value <= value;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Response side. A requested hold keeps ready low for a long stretch so that
	// the block backs up and stalls the request channel.
	initial begin
		int gap;
		rsp_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			if (hold_pending) begin
				rsp_ch.ready <= 1'b0;
				hold_pending = 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = draw_wait();
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	initial begin
		logic signed [clsd_pkg::DATAW-1:0] pool[4];
		logic signed [clsd_pkg::DATAW-1:0] value;
		int pool_size, len, roll, insert_pct, random_sent, epoch;
		req_ch.valid      <= 1'b0;
		req_ch.req_type   <= clsd_pkg::REQ_INS_FRONT;
		req_ch.item_value <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Empty list, extreme values, misses, filling up and deleting the head.
		send_item(clsd_pkg::REQ_SEARCH, 0);
		send_item(clsd_pkg::REQ_DELETE, 0);
		send_item(clsd_pkg::REQ_INS_FRONT, 32'h8000_0000);
		send_item(clsd_pkg::REQ_INS_BACK, 32'h7FFF_FFFF);
		send_item(clsd_pkg::REQ_INS_FRONT, '1);
		send_item(clsd_pkg::REQ_INS_BACK, 0);
		send_item(clsd_pkg::REQ_SEARCH, 32'h7FFF_FFFF);
		send_item(clsd_pkg::REQ_SEARCH, 5);
		send_item(clsd_pkg::REQ_DELETE, 5);
		repeat (clsd_pkg::CAPACITY - 4) send_item(clsd_pkg::REQ_INS_BACK, 7);
		send_item(clsd_pkg::REQ_INS_FRONT, 1);
		send_item(clsd_pkg::REQ_INS_BACK, 1);
		send_item(clsd_pkg::REQ_SEARCH, 7);
		send_item(clsd_pkg::REQ_DELETE, 7);
		send_item(clsd_pkg::REQ_DELETE, '1);
		send_item(clsd_pkg::REQ_DELETE, 32'h8000_0000);
		send_item(clsd_pkg::REQ_DELETE, 32'h7FFF_FFFF);
		send_item(clsd_pkg::REQ_DELETE, 0);

		// Each epoch works on a small pool of values so that matches are common,
		// then deletes the pool so the list is empty again.
		random_sent = 0;
		epoch = 0;
		while (random_sent < RANDOM_ITEMS) begin
			pool_size = $urandom_range(1, 4);
			for (int k = 0; k < 4; k++)
				pool[k] = ($urandom_range(0, 4) == 0) ? corner_value() : $urandom();
			insert_pct = $urandom_range(0, 1) ? 60 : 35;
			len = $urandom_range(30, 60);
			idle_on = ($urandom_range(0, 3) != 0);
			if (epoch == 1)
				hold_pending = 1'b1;
			repeat (len) begin
				roll = $urandom_range(0, 99);
				value = ($urandom_range(0, 4) == 0) ? $urandom()
					: pool[$urandom_range(0, pool_size - 1)];
				if (roll < insert_pct)
					send_item($urandom_range(0, 1) ? clsd_pkg::REQ_INS_FRONT
						: clsd_pkg::REQ_INS_BACK,
						pool[$urandom_range(0, pool_size - 1)]);
				else if (roll < 85)
					send_item(clsd_pkg::REQ_SEARCH, value);
				else
					send_item(clsd_pkg::REQ_DELETE, value);
			end
			for (int k = 0; k < pool_size; k++)
				send_item(clsd_pkg::REQ_DELETE, pool[k]);
			random_sent += len + pool_size;
			// Fill the empty list with one value: a full search and a full delete.
			if (epoch % 3 == 2) begin
				value = $urandom();
				repeat (clsd_pkg::CAPACITY + 1)
					send_item($urandom_range(0, 1) ? clsd_pkg::REQ_INS_FRONT
						: clsd_pkg::REQ_INS_BACK, value);
				send_item(clsd_pkg::REQ_SEARCH, value);
				send_item(clsd_pkg::REQ_DELETE, value);
				random_sent += clsd_pkg::CAPACITY + 3;
			end
			epoch++;
		end
		req_ch.valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
